/* design/fds_pkg.sv */
// Shared widths, register indexes, reset values and beat layouts for the fall detect sequencer.
package fds_pkg;

  localparam int unsigned AXIS_W   = 16;
  localparam int unsigned MG_W     = 12;
  localparam int unsigned TICKS_W  = 8;
  localparam int unsigned STATUS_W = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 12;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_REFERENCE  = 2'd2;

  // Register reset values
  localparam logic [TICKS_W-1:0] SETTLE_TICKS_RST = 8'd20;
  localparam logic [MG_W-1:0]    AXIS_LIMIT_RST   = 12'd500;
  localparam logic [MG_W-1:0]    Y_REFERENCE_RST  = 12'd1000;

  // Interrupt source bits
  localparam int unsigned ST_FREEFALL_BIT  = 2;
  localparam int unsigned ST_TRANSIENT_BIT = 5;

  // Beat widths
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 8;

  // One result beat
  typedef struct packed {
    logic       timer_running;
    logic [2:0] step_flags;
    logic       fall_alarm;
  } fds_result_t;

endpackage

/* design/fds_axis_mg.sv */
// Converts one raw left-justified accelerometer word into a milli-g magnitude.
module fds_axis_mg
  import fds_pkg::*;
(
  input  logic [AXIS_W-1:0] raw,
  output logic [MG_W-1:0]   mg
);

  logic [AXIS_W-1:0] mag;
  logic [13:0]       counts;
  logic [19:0]       scaled;

  // Take magnitude; the most negative word keeps its pattern
  assign mag    = raw[AXIS_W-1] ? (~raw + 16'd1) : raw;
  // Drop the two unused low bits, then scale by 125/256
  assign counts = mag[AXIS_W-1:2];
  assign scaled = {6'd0, counts} * 20'd125;
  assign mg     = scaled[19:8];

endmodule

/* design/fall_detect_sequencer.sv */
// Top level of the fall detect sequencer: step tracking, settle counter and result buffer.
//
//  channel  | direction | beat contents (low bit first)
//  ---------+-----------+--------------------------------------------------
//  in_      | slave     | tuser: int_valid; tdata: irq_src, tick, x, y, z
//  out_     | master    | tdata: fall_alarm, step_flags[2:0], timer_running
//  cfg_     | write     | cfg_addr selects settle/limit/reference register
//
// One input beat per cycle while in_tready is high; each beat yields one result
// beat, registered on acceptance. The step logic and the three constant scalers
// sit between the input port and the result register. A two-entry result buffer
// (output register plus skid) lets a beat be accepted while a result waits;
// in_tready drops only when both entries are full. Reset is synchronous and
// restores the step flags, the counter and the registers to their defaults.
module fall_detect_sequencer
  import fds_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: irq_src[7:0], tick[8], accel_x[24:9], accel_y[40:25],
  //           accel_z[56:41], zero[63:57]
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: int_valid[0]
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_tdata: fall_alarm[0], step_flags[3:1], timer_running[4], zero[7:5]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_addr,
  input  logic [CFG_DAT_W-1:0]   cfg_wdata
);

  logic [TICKS_W-1:0] settle_ticks_r;
  logic [MG_W-1:0]    axis_limit_r;
  logic [MG_W-1:0]    y_reference_r;

  logic               freefall_r, transient_r, settled_r, running_r;
  logic [TICKS_W-1:0] count_r;
  logic               freefall_nxt, transient_nxt, settled_nxt, running_nxt;
  logic [TICKS_W-1:0] count_nxt;

  fds_result_t        main_r, skid_r, result;
  logic               main_valid_r, skid_valid_r;

  logic               int_valid, tick;
  logic [STATUS_W-1:0] irq_src;
  logic [AXIS_W-1:0]  accel_x, accel_y, accel_z;
  logic [MG_W-1:0]    x_mg, y_mg, z_mg;

  logic               push, pop;
  logic               ff_set, tr_set, ff_a, tr_a, run_a;
  logic [TICKS_W-1:0] count_inc;
  logic               limit_hit, settled_b, armed, alarm;
  logic signed [13:0] y_margin;

  // Unpack the input beat
  assign int_valid  = in_tuser;
  assign irq_src    = in_tdata[7:0];
  assign tick       = in_tdata[8];
  assign accel_x    = in_tdata[24:9];
  assign accel_y    = in_tdata[40:25];
  assign accel_z    = in_tdata[56:41];

  fds_axis_mg u_x_mg (.raw(accel_x), .mg(x_mg));
  fds_axis_mg u_y_mg (.raw(accel_y), .mg(y_mg));
  fds_axis_mg u_z_mg (.raw(accel_z), .mg(z_mg));

  assign push = in_tvalid && in_tready;
  assign pop  = main_valid_r && out_tready;

  // Step logic for the beat at the port
  always_comb begin
    ff_set      = int_valid && irq_src[ST_FREEFALL_BIT];
    ff_a        = freefall_r || ff_set;
    tr_set      = int_valid && irq_src[ST_TRANSIENT_BIT] && ff_a;
    tr_a        = transient_r || tr_set;
    run_a       = running_r || tr_set;
    count_inc   = count_r + 8'd1;
    limit_hit   = tick && run_a && (count_inc == settle_ticks_r);
    settled_b   = settled_r || (limit_hit && ff_a && tr_a);
    running_nxt = run_a && !limit_hit;
    if (tick && run_a) begin
      count_nxt = limit_hit ? '0 : count_inc;
    end else begin
      count_nxt = count_r;
    end
    armed    = ff_a && tr_a && settled_b;
    y_margin = $signed({2'b00, y_reference_r}) - $signed({2'b00, y_mg});
    alarm    = armed && ((x_mg > axis_limit_r) || (z_mg > axis_limit_r) ||
                         (y_margin > $signed({2'b00, axis_limit_r})));
    freefall_nxt  = ff_a && !armed;
    transient_nxt = tr_a && !armed;
    settled_nxt   = settled_b && !armed;
    result.fall_alarm    = alarm;
    result.step_flags    = {settled_nxt, transient_nxt, freefall_nxt};
    result.timer_running = running_nxt;
  end

  // Advance sequencer state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freefall_r  <= 1'b0;
      transient_r <= 1'b0;
      settled_r   <= 1'b0;
      running_r   <= 1'b0;
      count_r     <= '0;
    end else if (push) begin
      freefall_r  <= freefall_nxt;
      transient_r <= transient_nxt;
      settled_r   <= settled_nxt;
      running_r   <= running_nxt;
      count_r     <= count_nxt;
    end
  end

  // Configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_ticks_r <= SETTLE_TICKS_RST;
      axis_limit_r   <= AXIS_LIMIT_RST;
      y_reference_r  <= Y_REFERENCE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_SETTLE_TICKS: settle_ticks_r <= cfg_wdata[TICKS_W-1:0];
        REG_AXIS_LIMIT:   axis_limit_r   <= cfg_wdata;
        REG_Y_REFERENCE:  y_reference_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Result buffer: output register with a skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!main_valid_r || pop) begin
      main_valid_r <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid_r || pop) begin
      main_r <= skid_valid_r ? skid_r : result;
    end else if (push) begin
      skid_r <= result;
    end
  end

  assign in_tready  = !skid_valid_r;
  assign out_tvalid = main_valid_r;
  assign out_tdata  = {3'b000, main_r};

  // Skid entry is only ever filled behind a held output beat
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid entry valid without output beat");

  // Counter stays cleared whenever the settle timer is stopped
  a_idle_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |-> (count_r == '0))
    else $error("settle count nonzero while timer stopped");

  // Transient step never stands without the free-fall step
  a_step_order: assert property (@(posedge clk) disable iff (!rst_n)
    transient_r |-> freefall_r)
    else $error("transient step set without free-fall step");

  // A held output beat keeps its contents
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result beat changed");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the fall detect sequencer: stream stimulus, step predictor, checks.
module testbench
  import fds_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Index that no register answers to
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Predict the step flags and alarm of each accepted beat and check the result stream
  class fall_step_scoreboard;
    logic [TICKS_W-1:0] settle_ticks;
    logic [MG_W-1:0]    axis_limit;
    logic [MG_W-1:0]    y_ref;
    bit                 freefall;
    bit                 transient;
    bit                 settled;
    bit                 running;
    logic [TICKS_W-1:0] count;
    fds_result_t        step_results_q[$];
    int                 errors;

    function new();
      settle_ticks = SETTLE_TICKS_RST;
      axis_limit   = AXIS_LIMIT_RST;
      y_ref        = Y_REFERENCE_RST;
      freefall     = 0;
      transient    = 0;
      settled      = 0;
      running      = 0;
      count        = '0;
      errors       = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
      case (idx)
        REG_SETTLE_TICKS: settle_ticks = val[TICKS_W-1:0];
        REG_AXIS_LIMIT:   axis_limit = val[MG_W-1:0];
        REG_Y_REFERENCE:  y_ref = val[MG_W-1:0];
        default: ;
      endcase
    endfunction

    // Magnitude, drop two bits, scale to milli-g
    static function int axis_mg(logic [AXIS_W-1:0] raw);
      logic [AXIS_W-1:0] mag;
      int                m;
      mag = raw;
      if (mag[AXIS_W-1]) mag = -mag;
      m = int'(mag >> 2);
      return (m * 125) >> 8;
    endfunction

    function void take_sample_beat(bit int_valid, logic [STATUS_W-1:0] status, bit tick,
                                   logic [AXIS_W-1:0] x, logic [AXIS_W-1:0] y,
                                   logic [AXIS_W-1:0] z);
      fds_result_t want;
      int          lim;
      int          yref;
      want = '0;
      // Status byte: free-fall first, then transient
      if (int_valid) begin
        if (status[ST_FREEFALL_BIT]) freefall = 1;
        if (status[ST_TRANSIENT_BIT] && freefall) begin
          transient = 1;
          running   = 1;
        end
      end
      // Advance the settle counter
      if (tick && running) begin
        count = count + 1'b1;
        if (count == settle_ticks) begin
          if (freefall && transient) settled = 1;
          count   = '0;
          running = 0;
        end
      end
      // Orientation check once all three steps are in
      if (freefall && transient && settled) begin
        lim  = int'(axis_limit);
        yref = int'(y_ref);
        want.fall_alarm = (axis_mg(x) > lim) || (yref - axis_mg(y) > lim) ||
                          (axis_mg(z) > lim);
        freefall  = 0;
        transient = 0;
        settled   = 0;
      end
      want.step_flags    = {settled, transient, freefall};
      want.timer_running = running;
      step_results_q.push_back(want);
    endfunction

    function void check_step_result(logic [OUT_TDATA_W-1:0] beat);
      fds_result_t got;
      fds_result_t want;
      got = beat[$bits(fds_result_t)-1:0];
      if (step_results_q.size() == 0) begin
        errors++;
        $display("%0t: result beat %h with nothing expected", $realtime, beat);
        return;
      end
      want = step_results_q.pop_front();
      if (got.fall_alarm !== want.fall_alarm) begin
        errors++;
        $display("%0t: fall_alarm expected %0d actual %0d", $realtime,
                 want.fall_alarm, got.fall_alarm);
      end
      if (got.step_flags !== want.step_flags) begin
        errors++;
        $display("%0t: step_flags expected %b actual %b", $realtime,
                 want.step_flags, got.step_flags);
      end
      if (got.timer_running !== want.timer_running) begin
        errors++;
        $display("%0t: timer_running expected %0d actual %0d", $realtime,
                 want.timer_running, got.timer_running);
      end
    endfunction

    function int pending();
      return step_results_q.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en;
  logic [CFG_IDX_W-1:0]   cfg_addr;
  logic [CFG_DAT_W-1:0]   cfg_wdata;

  fall_step_scoreboard sb = new();
  bit                  steady = 0;
  bit                  hold_req = 0;
  int                  hold_left = 0;
  int                  items_sent = 0;

  fall_detect_sequencer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Check result beats; stall at random, with long hold-offs on request
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_step_result(out_tdata);
    if (hold_req) begin
      hold_left = 80;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady || ($urandom_range(0, 99) >= 22);
    end
  end

  // Raw word whose milli-g reading is mg, optionally negated
  function automatic logic [AXIS_W-1:0] raw_from_mg(int mg, bit neg);
    int                m;
    logic [AXIS_W-1:0] raw;
    m = (mg * 256 + 124) / 125;
    if (m > 8191) m = 8191;
    raw = AXIS_W'(m * 4) | AXIS_W'($urandom_range(0, 3));
    if (neg) raw = -raw;
    return raw;
  endfunction

  // Mostly near a threshold, sometimes a corner or anything at all
  function automatic logic [AXIS_W-1:0] pick_axis(int centre);
    int r;
    int mg;
    r = $urandom_range(0, 9);
    if (r == 0) return AXIS_W'($urandom);
    if (r == 1) begin
      case ($urandom_range(0, 3))
        0: return 16'h8000;
        1: return 16'h7FFF;
        2: return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end
    mg = centre + int'($urandom_range(0, 40)) - 20;
    if (mg < 0) mg = 0;
    if (mg > 4000) mg = 4000;
    return raw_from_mg(mg, $urandom_range(0, 1));
  endfunction

  // Offer one sample beat, after a random gap unless steady, and wait for acceptance
  task automatic send_beat(input bit iv, input logic [STATUS_W-1:0] status, input bit tick,
                           input logic [AXIS_W-1:0] x, input logic [AXIS_W-1:0] y,
                           input logic [AXIS_W-1:0] z);
    if (!steady) begin
      while ($urandom_range(0, 99) < 22) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= iv;
    in_tdata  <= {7'd0, z, y, x, tick, status};
    do @(posedge clk); while (!in_tready);
    sb.take_sample_beat(iv, status, tick, x, y, z);
    items_sent++;
  endtask

  task automatic send_noise();
    send_beat($urandom_range(0, 1), STATUS_W'($urandom), $urandom_range(0, 1),
              AXIS_W'($urandom), AXIS_W'($urandom), AXIS_W'($urandom));
  endtask

  // Free-fall (mostly), transient, then ticks until the settle check has been made
  task automatic run_fall_sequence();
    logic [STATUS_W-1:0] st;
    int                  guard;
    if ($urandom_range(0, 9) != 0) begin
      st = STATUS_W'($urandom);
      st[ST_TRANSIENT_BIT] = 1'b0;
      st[ST_FREEFALL_BIT]  = 1'b1;
      send_beat(1'b1, st, $urandom_range(0, 1), AXIS_W'($urandom), AXIS_W'($urandom),
                AXIS_W'($urandom));
    end
    repeat ($urandom_range(0, 2)) send_noise();
    st = STATUS_W'($urandom);
    st[ST_TRANSIENT_BIT] = 1'b1;
    send_beat(1'b1, st, $urandom_range(0, 1), AXIS_W'($urandom), AXIS_W'($urandom),
              AXIS_W'($urandom));
    guard = 0;
    while (sb.running && guard < 1000) begin
      send_beat($urandom_range(0, 3) == 0, STATUS_W'($urandom), $urandom_range(0, 4) != 0,
                pick_axis(int'(sb.axis_limit)),
                pick_axis(int'(sb.y_ref) - int'(sb.axis_limit)),
                pick_axis(int'(sb.axis_limit)));
      guard++;
    end
  endtask

  // Drop valid and wait until every result is back and the block is quiet
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all registers, then a junk write to the unused index
  task automatic configure(input logic [TICKS_W-1:0] ticks, input logic [MG_W-1:0] limit,
                           input logic [MG_W-1:0] yref);
    logic [CFG_IDX_W-1:0] idx  [4];
    logic [CFG_DAT_W-1:0] data [4];
    idx[0]  = REG_SETTLE_TICKS;
    data[0] = {4'($urandom), ticks};
    idx[1]  = REG_AXIS_LIMIT;
    data[1] = limit;
    idx[2]  = REG_Y_REFERENCE;
    data[2] = yref;
    idx[3]  = REG_UNUSED;
    data[3] = CFG_DAT_W'($urandom);
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_addr  <= idx[i];
      cfg_wdata <= data[i];
      @(posedge clk);
      sb.write_reg(idx[i], data[i]);
    end
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : stimulus
    int ph_ticks [7] = '{3, 1, 255, 5, 0, 20, 2};
    int ph_limit [7] = '{500, 0, 4095, 2000, 123, 500, 0};
    int ph_yref  [7] = '{1000, 0, 4095, 4095, 2048, 1000, 0};
    // Long settle phases run one sequence of about 320 beats each
    int ph_items [7] = '{200, 200, 150, 200, 250, 200, 180};
    int start;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = 1'b0;
    in_tdata  = '0;
    cfg_wr_en = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: ignored inputs, same-byte steps, retrigger, limit edges
    configure(8'd2, 12'd500, 12'd1000);
    send_beat(1'b0, 8'h24, 1'b1, 16'h0000, 16'h0000, 16'h0000);
    send_beat(1'b1, 8'h20, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_beat(1'b1, 8'hDB, 1'b1, 16'h0000, 16'h0000, 16'h0000);
    send_beat(1'b1, 8'h24, 1'b0, 16'h0000, 16'h0000, 16'h0000);
    send_beat(1'b1, 8'h20, 1'b1, 16'h0000, 16'h0000, 16'h0000);
    send_beat(1'b0, 8'h00, 1'b1, 16'h8000, 16'h7FFF, 16'h0000);
    send_beat(1'b1, 8'hFB, 1'b0, 16'h0000, 16'h0000, 16'h0000);
    send_beat(1'b1, 8'hFF, 1'b1, 16'h0000, 16'h0000, 16'h0000);
    send_beat(1'b0, 8'hFF, 1'b1, raw_from_mg(500, 1), raw_from_mg(500, 0),
              raw_from_mg(500, 0));
    send_beat(1'b1, 8'h04, 1'b0, 16'h0000, 16'h0000, 16'h0000);
    send_beat(1'b1, 8'h20, 1'b1, 16'h0000, 16'h0000, 16'h0000);
    send_beat(1'b0, 8'h00, 1'b1, 16'h0000, 16'h7FFF, raw_from_mg(501, 1));
    send_beat(1'b1, 8'h04, 1'b0, 16'h0000, 16'h0000, 16'h0000);
    send_beat(1'b1, 8'h20, 1'b1, 16'h0000, 16'h0000, 16'h0000);
    send_beat(1'b0, 8'h00, 1'b1, 16'hFFFF, raw_from_mg(499, 0), 16'hFFFC);
    send_beat(1'b1, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_beat(1'b1, 8'h00, 1'b1, 16'hFFFF, 16'h7FFF, 16'hFFFF);
    send_beat(1'b0, 8'h00, 1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF);

    // Random phases over a range of settings, counts left running across writes
    ph_limit[6] = $urandom_range(0, 4095);
    ph_yref[6]  = $urandom_range(0, 4095);
    for (int p = 0; p < 7; p++) begin
      drain();
      configure(TICKS_W'(ph_ticks[p]), MG_W'(ph_limit[p]), MG_W'(ph_yref[p]));
      steady = (p == 5);
      if (p == 0 || p == 3) hold_req = 1;
      start = items_sent;
      while (items_sent - start < ph_items[p]) begin
        if ($urandom_range(0, 99) < 75) run_fall_sequence();
        else send_noise();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** fall_detect_sequencer: PASSED **");
    end else begin
      $display("** fall_detect_sequencer: FAILED **");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("** fall_detect_sequencer: FAILED **");
    $finish;
  end

endmodule

/* fall_detect_sequencer.f */
design/fds_pkg.sv
design/fds_axis_mg.sv
design/fall_detect_sequencer.sv
tb/testbench.sv
